[sv/ambient_light_dimmer_top_assert.svh]
// Assertion macros shared by the ambient light dimmer RTL.
// Each macro expects clk and rst_n to be visible in the module that uses it.
`ifndef AMBIENT_LIGHT_DIMMER_TOP_ASSERT_SVH
`define AMBIENT_LIGHT_DIMMER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ALD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ALD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/ald_pkg.sv]
// Shared types and constants for the ambient light dimmer.
// No dependencies; all other source files but the macro header import it.
`default_nettype none

package ald_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int DUTY_W     = 8;
    localparam int WINDOW_DEF = 16;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    // Divider numerator covers (light_limit - mean) * duty_max (20 bits).
    localparam int NUM_W      = SAMPLE_W + DUTY_W;
    localparam int DIV_CNT_W  = $clog2(NUM_W + 1);

    localparam logic [SAMPLE_W-1:0] LIGHT_LIMIT_RST = SAMPLE_W'(600);
    localparam logic [DUTY_W-1:0]   DUTY_MAX_RST    = DUTY_W'(200);

    // Register select taken from paddr[2]
    typedef enum logic {
        REG_LIGHT_LIMIT = 1'b0,
        REG_DUTY_MAX    = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic                start;
        logic [NUM_W-1:0]    numer;
        logic [SAMPLE_W-1:0] denom;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [NUM_W-1:0] quot;
    } div_rsp_t;

endpackage

`default_nettype wire

[sv/ald_if.sv]
// Channel interfaces: sample input beats and result output beats.
// Depends on ald_pkg for field widths.
`default_nettype none

interface ald_sample_if import ald_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface ald_result_if import ald_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] mean_reading;
    logic [DUTY_W-1:0]   duty;

    modport source (output valid, output mean_reading, output duty, input ready);
    modport sink   (input valid, input mean_reading, input duty, output ready);
endinterface

`default_nettype wire

[sv/ald_queue.sv]
// Two-entry queue of running sums between the front and back parts.
// Depends on ald_pkg and the assertion macro header.
`default_nettype none
`include "ambient_light_dimmer_top_assert.svh"

module ald_queue import ald_pkg::*; #(
    parameter int SUM_W = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [SUM_W-1:0] push_data,
    input  wire logic             pop,
    output q_stat_t               stat,
    output logic      [SUM_W-1:0] head
);

    logic [SUM_W-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;

    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);
    assign head       = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed sum
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `ALD_ASSERT_SAME(a_no_push_full, push, !stat.full, "push into full queue")
    `ALD_ASSERT_SAME(a_no_pop_empty, pop, !stat.empty, "pop from empty queue")
    `ALD_ASSERT_NEXT(a_push_fills, push && !pop, !stat.empty, "pushed beat lost")

endmodule

`default_nettype wire

[sv/ald_divider.sv]
// Serial restoring divider, one quotient bit per cycle, NUM_W quotient bits in all.
// Depends on ald_pkg and the assertion macro header.
`default_nettype none
`include "ambient_light_dimmer_top_assert.svh"

module ald_divider import ald_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic [NUM_W-1:0]     num_reg;
    logic [NUM_W-1:0]     num_next;
    logic [SAMPLE_W-1:0]  rem_reg;
    logic [SAMPLE_W-1:0]  rem_next;
    logic [SAMPLE_W-1:0]  den_reg;
    logic [SAMPLE_W-1:0]  den_next;
    logic [SAMPLE_W:0]    trial;
    logic [SAMPLE_W:0]    diff;
    logic                 fits;

    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    // Load on start, then shift one quotient bit per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(NUM_W);
            num_next  = req.numer;
            rem_next  = '0;
            den_next  = req.denom;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[NUM_W-2:0], fits};
            rem_next = fits ? diff[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = num_reg;

    `ALD_ASSERT_SAME(a_start_idle, req.start, !busy_reg, "divider restarted while busy")
    `ALD_ASSERT_NEXT(a_start_busy, req.start, busy_reg && !done_reg, "divider did not launch")
    `ALD_ASSERT_SAME(a_busy_count, busy_reg, cnt_reg != '0, "busy divider with zero count")

endmodule

`default_nettype wire

[sv/ald_front.sv]
// Front part: accepts samples, keeps the sample ring and the running sum.
// Depends on ald_pkg and ald_sample_if; pushes each new sum into ald_queue.
`default_nettype none

module ald_front import ald_pkg::*; #(
    parameter int WINDOW = WINDOW_DEF,
    parameter int SUM_W  = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    ald_sample_if.sink       samples,
    input  wire q_stat_t     q_stat,
    output logic             push,
    output logic [SUM_W-1:0] push_data
);

    localparam int PTR_W = $clog2(WINDOW);

    logic [SAMPLE_W-1:0] ring_mem [WINDOW];
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [SAMPLE_W-1:0] first_reg;
    logic                pend_reg;
    logic                pend_next;
    logic                primed_reg;
    logic                primed_next;
    logic                lap_reg;
    logic                lap_next;
    logic [PTR_W-1:0]    wpos_reg;
    logic [PTR_W-1:0]    wpos_next;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    sum_next;
    logic [SAMPLE_W-1:0] oldest;
    logic                accept;

    assign samples.ready = !pend_reg && !q_stat.full;
    assign accept        = samples.valid && samples.ready;

    // Entries not yet overwritten since priming still hold the first sample
    assign oldest = lap_reg ? rd_data_reg : first_reg;

    // Update ring state in the cycle after a beat is accepted
    always_comb
    begin
        pend_next   = accept;
        primed_next = primed_reg;
        lap_next    = lap_reg;
        wpos_next   = wpos_reg;
        sum_next    = sum_reg;
        if (pend_reg)
        begin
            if (!primed_reg)
            begin
                sum_next    = SUM_W'(SUM_W'(sample_reg) * SUM_W'(WINDOW));
                primed_next = 1'b1;
                lap_next    = 1'b0;
                wpos_next   = '0;
            end
            else
            begin
                sum_next = sum_reg - SUM_W'(oldest) + SUM_W'(sample_reg);
                if (wpos_reg == PTR_W'(WINDOW - 1))
                begin
                    wpos_next = '0;
                    lap_next  = 1'b1;
                end
                else
                begin
                    wpos_next = wpos_reg + PTR_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg   <= 1'b0;
            primed_reg <= 1'b0;
            lap_reg    <= 1'b0;
            wpos_reg   <= '0;
            sum_reg    <= '0;
        end
        else
        begin
            pend_reg   <= pend_next;
            primed_reg <= primed_next;
            lap_reg    <= lap_next;
            wpos_reg   <= wpos_next;
            sum_reg    <= sum_next;
        end
    end

    // Hold the sample and read the oldest entry on accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg  <= samples.sample;
            rd_data_reg <= ring_mem[wpos_reg];
        end
        if (pend_reg && !primed_reg)
        begin
            first_reg <= sample_reg;
        end
    end

    // Overwrite the oldest entry
    always_ff @(posedge clk)
    begin
        if (pend_reg && primed_reg)
        begin
            ring_mem[wpos_reg] <= sample_reg;
        end
    end

    assign push      = pend_reg;
    assign push_data = sum_next;

endmodule

`default_nettype wire

[sv/ald_back.sv]
// Back part: mean by reciprocal multiply, duty mapping by multiply and division, result beat.
// Depends on ald_pkg, ald_result_if and ald_divider.
`default_nettype none

module ald_back import ald_pkg::*; #(
    parameter int WINDOW = WINDOW_DEF,
    parameter int SUM_W  = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire q_stat_t             q_stat,
    input  wire logic [SUM_W-1:0]    head,
    output logic                     pop,
    input  wire logic [SAMPLE_W-1:0] light_limit,
    input  wire logic [DUTY_W-1:0]   duty_max,
    ald_result_if.source             results
);

    // floor(sum / WINDOW) as (sum * MEAN_RECIP) >> MEAN_SHIFT, exact for any sum
    // below 2**SUM_W
    localparam int             MEAN_SHIFT = SUM_W + $clog2(WINDOW);
    localparam logic [SUM_W:0] MEAN_RECIP =
        (SUM_W+1)'(((64'd1 << MEAN_SHIFT) / 64'(WINDOW)) + 64'd1);

    typedef enum logic [4:0] {
        B_IDLE     = 5'b00001,
        B_PROD     = 5'b00010,
        B_SCALE_GO = 5'b00100,
        B_SCALE    = 5'b01000,
        B_OUT      = 5'b10000
    } back_state_t;

    back_state_t         state_reg;
    back_state_t         state_next;
    logic [SAMPLE_W-1:0] mean_reg;
    logic [SAMPLE_W-1:0] mean_next;
    logic [DUTY_W-1:0]   duty_reg;
    logic [DUTY_W-1:0]   duty_next;
    logic [NUM_W-1:0]    prod_reg;
    logic [NUM_W-1:0]    prod_next;
    logic [SAMPLE_W-1:0] headroom;
    logic [2*SUM_W:0]    mean_prod;
    logic [SAMPLE_W-1:0] mean_calc;
    div_req_t            div_req;
    div_rsp_t            div_rsp;

    assign headroom = light_limit - mean_reg;
    assign pop      = (state_reg == B_IDLE) && !q_stat.empty;

    // Mean of the sum at the head of the queue
    assign mean_prod = (2*SUM_W+1)'(head) * (2*SUM_W+1)'(MEAN_RECIP);
    assign mean_calc = mean_prod[MEAN_SHIFT +: SAMPLE_W];

    // Launch the divider for the duty scale
    assign div_req.start = (state_reg == B_SCALE_GO);
    assign div_req.numer = prod_reg;
    assign div_req.denom = light_limit;

    ald_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Sequence one sum through to a result beat
    always_comb
    begin
        state_next = state_reg;
        mean_next  = mean_reg;
        duty_next  = duty_reg;
        prod_next  = prod_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (pop)
                begin
                    mean_next  = mean_calc;
                    state_next = B_PROD;
                end
            end
            B_PROD:
            begin
                if (mean_reg >= light_limit)
                begin
                    duty_next  = '0;
                    state_next = B_OUT;
                end
                else
                begin
                    prod_next  = NUM_W'(headroom) * NUM_W'(duty_max);
                    state_next = B_SCALE_GO;
                end
            end
            B_SCALE_GO:
            begin
                state_next = B_SCALE;
            end
            B_SCALE:
            begin
                if (div_rsp.done)
                begin
                    duty_next  = div_rsp.quot[DUTY_W-1:0];
                    state_next = B_OUT;
                end
            end
            B_OUT:
            begin
                if (results.ready)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mean_reg <= mean_next;
        duty_reg <= duty_next;
        prod_reg <= prod_next;
    end

    assign results.valid        = (state_reg == B_OUT);
    assign results.mean_reading = mean_reg;
    assign results.duty         = duty_reg;

endmodule

`default_nettype wire

[sv/ambient_light_dimmer_top.sv]
// Ambient light dimmer: moving average of light samples mapped to a PWM duty.
//
// Channels: samples (valid/ready, 12-bit sample) in, results (valid/ready,
// 12-bit mean_reading and 8-bit duty) out, one result beat per sample beat.
// Configuration through a small APB port: light_limit at 0x0, duty_max at 0x4
// (paddr[2] selects the register); the user must write them only while idle, unenforced.
//
// When the mean is at or above light_limit the divider is skipped. The front
// takes no new sample while it still updates the ring for the last one or the
// sum queue is full. The mean comes from a reciprocal multiply and the duty
// scale runs a one-bit-per-cycle serial divider by light_limit; the back takes
// the next sum from the queue only once its last result beat has been taken.
//
// Reset clears the ring position, running sum and primed flag; the first
// sample after reset stands for every ring entry. Config resets to
// light_limit = 600, duty_max = 200.
//
// When the result receiver stalls, the finished result is held; the front
// keeps accepting samples until the two-entry sum queue fills.
// Depends on ald_pkg, ald_if, ald_front, ald_queue and ald_back.
`default_nettype none

module ambient_light_dimmer_top import ald_pkg::*; #(
    parameter int WINDOW = WINDOW_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    ald_sample_if.sink              samples,
    ald_result_if.source            results,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    localparam int SUM_W = $clog2(WINDOW * ((1 << SAMPLE_W) - 1) + 1);

    logic [SAMPLE_W-1:0] light_limit_reg;
    logic [DUTY_W-1:0]   duty_max_reg;
    reg_idx_t            reg_sel;
    logic                cfg_write;
    logic                push;
    logic [SUM_W-1:0]    push_data;
    logic                pop;
    logic [SUM_W-1:0]    head;
    q_stat_t             q_stat;

    assign pready    = 1'b1;
    assign reg_sel   = reg_idx_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_limit_reg <= LIGHT_LIMIT_RST;
            duty_max_reg    <= DUTY_MAX_RST;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                REG_LIGHT_LIMIT: light_limit_reg <= pwdata[SAMPLE_W-1:0];
                REG_DUTY_MAX:    duty_max_reg    <= pwdata[DUTY_W-1:0];
                default:         light_limit_reg <= light_limit_reg;
            endcase
        end
    end

    // Read back configuration registers
    always_comb
    begin
        unique case (reg_sel)
            REG_LIGHT_LIMIT: prdata = PDATA_W'(light_limit_reg);
            REG_DUTY_MAX:    prdata = PDATA_W'(duty_max_reg);
            default:         prdata = '0;
        endcase
    end

    ald_front #(
        .WINDOW (WINDOW),
        .SUM_W  (SUM_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    ald_queue #(
        .SUM_W (SUM_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .stat      (q_stat),
        .head      (head)
    );

    ald_back #(
        .WINDOW (WINDOW),
        .SUM_W  (SUM_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_stat      (q_stat),
        .head        (head),
        .pop         (pop),
        .light_limit (light_limit_reg),
        .duty_max    (duty_max_reg),
        .results     (results)
    );

endmodule

`default_nettype wire

[bench/ambient_light_dimmer_top_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for the ambient light dimmer: drives sample beats and APB writes and
// checks each result beat against a moving-average and duty-map predictor.
// Depends on ald_pkg, ald_if and ambient_light_dimmer_top.

module ambient_light_dimmer_top_tb;
    import ald_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 120;

    typedef struct packed {
        logic [SAMPLE_W-1:0] mean;
        logic [DUTY_W-1:0]   duty;
    } dimmer_out_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    ald_sample_if samples_ch ();
    ald_result_if results_ch ();

    ambient_light_dimmer_top u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_ch),
        .results (results_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 clk = ~clk;

    // Predictor state: sample window, running sum and dimmer registers
    logic [SAMPLE_W-1:0] ring [WINDOW_DEF];
    int unsigned         ring_pos;
    int unsigned         ring_sum;
    bit                  ring_primed;
    int unsigned         cfg_light_limit;
    int unsigned         cfg_duty_max;

    dimmer_out_t         dimmer_expect_q [$];
    int                  send_idle_pct;
    int                  recv_idle_pct;
    int                  fail_count;
    int                  samples_sent;
    int                  results_checked;
    int                  settings_used;
    int                  idle_cycles;
    int                  last_sample;

    // Advance the window by one sample and map the new mean to a duty
    function automatic dimmer_out_t predict_dimmer(input logic [SAMPLE_W-1:0] s);
        dimmer_out_t r;
        int unsigned mean;
        if (!ring_primed) begin
            for (int i = 0; i < WINDOW_DEF; i++)
                ring[i] = s;
            ring_sum    = s * WINDOW_DEF;
            ring_pos    = 0;
            ring_primed = 1'b1;
        end
        else begin
            ring_sum       = ring_sum - ring[ring_pos] + s;
            ring[ring_pos] = s;
            ring_pos       = (ring_pos + 1) % WINDOW_DEF;
        end
        mean   = ring_sum / WINDOW_DEF;
        r.mean = mean[SAMPLE_W-1:0];
        if (mean >= cfg_light_limit)
            r.duty = '0;
        else
            r.duty = DUTY_W'(((cfg_light_limit - mean) * cfg_duty_max) / cfg_light_limit);
        return r;
    endfunction

    // Mix full-range, threshold-relative, rail and slowly drifting readings
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int hi;
        int v;
        hi = 2 * cfg_light_limit + 16;
        if (hi > 4095)
            hi = 4095;
        case ($urandom_range(4))
            0:       v = $urandom_range(4095);
            1, 2:    v = $urandom_range(hi);
            3:       v = $urandom_range(1) ? 4095 : 0;
            default: v = last_sample + int'($urandom_range(64)) - 32;
        endcase
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        last_sample = v;
        return SAMPLE_W'(v);
    endfunction

    // Send one sample beat, with random idle cycles ahead of it
    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            samples_ch.valid <= 1'b0;
            @(posedge clk);
        end
        samples_ch.valid  <= 1'b1;
        samples_ch.sample <= s;
        do
            @(posedge clk);
        while (!samples_ch.ready);
        dimmer_expect_q.push_back(predict_dimmer(s));
        samples_sent++;
    endtask

    // Drop valid and hold until every expected result beat is in
    task automatic wait_drained();
        samples_ch.valid <= 1'b0;
        while (dimmer_expect_q.size() != 0)
            @(posedge clk);
    endtask

    // APB write followed by a read back of the same register
    task automatic write_reg(input reg_idx_t idx, input int unsigned value);
        logic [PDATA_W-1:0] field_mask;
        field_mask = (idx == REG_LIGHT_LIMIT) ? PDATA_W'(12'hFFF) : PDATA_W'(8'hFF);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(int'(idx) * 4);
        pwdata  <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx == REG_LIGHT_LIMIT)
            cfg_light_limit = value & 12'hFFF;
        else
            cfg_duty_max = value & 8'hFF;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if ((prdata & field_mask) != (PDATA_W'(value) & field_mask))
        begin
            $display("%0t: register %s read back expected %0d actual %0d", $time,
                     idx.name(), value & field_mask, prdata & field_mask);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // First sample fills the window at reset settings, then climb to full scale
    task automatic test_priming_fill();
        send_sample(12'd0);
        for (int i = 0; i < WINDOW_DEF; i++)
            send_sample(12'hFFF);
        wait_drained();
    endtask

    // Register rails: mean equal to the threshold, then a zero threshold
    task automatic test_register_extremes();
        write_reg(REG_LIGHT_LIMIT, 4095);
        write_reg(REG_DUTY_MAX, 255);
        settings_used++;
        send_sample(12'hFFF);
        send_sample(12'hAAA);
        send_sample(12'h555);
        wait_drained();
        write_reg(REG_LIGHT_LIMIT, 0);
        settings_used++;
        send_sample(12'h000);
        send_sample(SAMPLE_W'($urandom_range(4095)));
        send_sample(12'h7FF);
        wait_drained();
    endtask

    // Random readings over three register settings at the given stall mix
    task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                       input int n_items);
        int unsigned rm;
        int unsigned dm;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        for (int k = 0; k < 3; k++)
        begin
            case (settings_used % 6)
                0:       begin rm = $urandom_range(1500, 1); dm = $urandom_range(255);    end
                1:       begin rm = 4095;                    dm = 255;                    end
                2:       begin rm = $urandom_range(4095, 1); dm = 0;                      end
                3:       begin rm = 0;                       dm = $urandom_range(255);    end
                4:       begin rm = 1;                       dm = 255;                    end
                default: begin rm = $urandom_range(4095);    dm = $urandom_range(255);    end
            endcase
            write_reg(REG_LIGHT_LIMIT, rm);
            write_reg(REG_DUTY_MAX, dm);
            settings_used++;
            for (int n = 0; n < n_items / 3; n++)
                send_sample(pick_sample());
            wait_drained();
        end
    endtask

    // Check result beats, count quiet cycles and randomize ready
    always @(posedge clk)
    begin : result_check
        dimmer_out_t want;
        if (rst_n && results_ch.valid && results_ch.ready)
        begin
            results_checked++;
            if (dimmer_expect_q.size() == 0)
            begin
                $display("%0t: unexpected result beat mean %0d duty %0d", $time,
                         results_ch.mean_reading, results_ch.duty);
                fail_count++;
            end
            else
            begin
                want = dimmer_expect_q.pop_front();
                if (results_ch.mean_reading !== want.mean)
                begin
                    $display("%0t: mean_reading expected %0d actual %0d", $time,
                             want.mean, results_ch.mean_reading);
                    fail_count++;
                end
                if (results_ch.duty !== want.duty)
                begin
                    $display("%0t: duty expected %0d actual %0d", $time,
                             want.duty, results_ch.duty);
                    fail_count++;
                end
            end
        end
        if (rst_n && ((samples_ch.valid && samples_ch.ready) ||
                      (results_ch.valid && results_ch.ready) ||
                      (psel && penable && pready)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        results_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // End the run if no beat moves for too long
    initial
    begin : watchdog
        wait (idle_cycles >= STALL_LIMIT);
        $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin : main
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        samples_ch.valid  = 1'b0;
        samples_ch.sample = '0;
        results_ch.ready  = 1'b0;
        ring_pos          = 0;
        ring_sum          = 0;
        ring_primed       = 1'b0;
        cfg_light_limit   = 600;
        cfg_duty_max      = 200;
        send_idle_pct     = 0;
        recv_idle_pct     = 0;
        fail_count        = 0;
        samples_sent      = 0;
        results_checked   = 0;
        settings_used     = 1;
        idle_cycles       = 0;
        last_sample       = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_priming_fill();
        test_register_extremes();
        test_random_traffic(12, 66, 360);
        test_random_traffic(66, 12, 360);
        test_random_traffic(0, 0, 360);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d result beats from %0d samples over %0d register settings,",
                 results_checked, samples_sent, settings_used);
        $display("including window priming, full-scale and zero thresholds, and stall mixes.");
        if (fail_count == 0 && dimmer_expect_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/ald_pkg.sv
sv/ald_if.sv
sv/ald_queue.sv
sv/ald_divider.sv
sv/ald_front.sv
sv/ald_back.sv
sv/ambient_light_dimmer_top.sv
bench/ambient_light_dimmer_top_tb.sv
